>>> rtl/core/itoa_pkg.sv
// Shared types and constants for the integer-to-ASCII radix converter.
// No dependencies; imported by the converter core and its checker.
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CHAR_W      = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_SIGNED = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN    = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPF   = 8'h46;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_EMIT,
        ST_BAD
    } itoa_state_t;

    // Map one digit to its ASCII code: '0'..'9', then 'A'..'F'.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
            c = CHAR_ZERO + {4'd0, d};
        else
            c = CHAR_UPA + {4'd0, d - 4'd10};
        return c;
    endfunction

endpackage

>>> rtl/core/itoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the digit store of the converter.
`timescale 1ns / 1ps

module itoa_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/integer_to_ascii_radix.sv
// Integer-to-ASCII converter top level: bit-serial divider, digit RAM, output beat register.
// Depends on itoa_pkg and itoa_ram.
`timescale 1ns / 1ps

// Converts one VALUE_WIDTH-bit integer per input beat into its text form, one
// ASCII character per output beat, most significant digit first, in the base
// held in the radix register (2..16, upper-case hex letters). In base 10 the
// value is signed and a leading '-' is sent; in other bases the bit pattern is
// unsigned. A radix outside 2..16 gives a single beat with character 0, last
// and invalid set. The divider is bit-serial, one quotient bit per clock;
// after division each character is read from the digit RAM and then loaded
// into the output register. The input takes one item at a time (in_stall
// is high from acceptance until the last character sits in the output
// register); the output register lets the next item be taken while the last
// beat waits.
// Write radix through cfg_we/cfg_data only while no conversion is in flight.
module integer_to_ascii_radix #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [itoa_pkg::RADIX_W-1:0]   cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [VALUE_WIDTH-1:0]  value,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [itoa_pkg::CHAR_W-1:0]    character,
    output logic                           last,
    output logic                           invalid
);

    import itoa_pkg::*;

    localparam int unsigned AW    = $clog2(VALUE_WIDTH);
    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int unsigned BIT_W = $clog2(VALUE_WIDTH);

    itoa_state_t state_reg, state_next;

    logic [RADIX_W-1:0]     radix_reg;
    logic [VALUE_WIDTH-1:0] work_reg, work_next;     // dividend in, quotient out
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   inv_reg, inv_next;

    logic                   in_accept;
    logic                   out_free;
    logic                   radix_ok;
    logic                   value_neg;
    logic [VALUE_WIDTH-1:0] value_mag;
    logic [RADIX_W-1:0]     rem_shift;
    logic                   q_bit;
    logic [RADIX_W-1:0]     rem_sub;
    logic [VALUE_WIDTH-1:0] quot;
    logic                   digit_done;
    logic [CNT_W-1:0]       cnt_minus;

    logic                   ram_we;
    logic                   ram_re;
    logic [DIGIT_W-1:0]     ram_rdata;

    // ---------------------------------------------------------------
    // Handshake and input decode
    // ---------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign radix_ok  = radix_reg inside {[RADIX_MIN:RADIX_MAX]};
    // Signed only in base 10; two's complement negate gives the right
    // magnitude even for the most negative value.
    assign value_neg = (radix_reg == RADIX_SIGNED) && value[VALUE_WIDTH-1];
    assign value_mag = value_neg ? (~value + 1'b1) : value;

    // ---------------------------------------------------------------
    // Bit-serial restoring division: one quotient bit per cycle.
    // The remainder stays below the radix (at most 15), so shift in one
    // dividend bit and subtract the radix when it fits.
    // ---------------------------------------------------------------
    assign rem_shift  = {rem_reg, work_reg[VALUE_WIDTH-1]};
    assign q_bit      = (rem_shift >= radix_reg);
    assign rem_sub    = q_bit ? (rem_shift - radix_reg) : rem_shift;
    assign quot       = {work_reg[VALUE_WIDTH-2:0], q_bit};
    assign digit_done = (state_reg == ST_DIV) && (bit_cnt_reg == BIT_W'(VALUE_WIDTH - 1));
    assign cnt_minus  = cnt_reg - 1'b1;

    // Digit store: write each finished remainder, read back in reverse.
    assign ram_we = digit_done;
    assign ram_re = (state_reg == ST_READ);

    itoa_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (rem_sub[DIGIT_W-1:0]),
        .re    (ram_re),
        .raddr (cnt_minus[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = radix_ok ? ST_DIV : ST_BAD;
            end
            ST_DIV:
            begin
                // Stop once the quotient runs out of digits.
                if (digit_done && (quot == '0))
                    state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                if (!neg_reg || out_free)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = (cnt_reg == '0) ? ST_IDLE : ST_READ;
            end
            ST_BAD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and output beat register
    // ---------------------------------------------------------------
    always_comb
    begin
        work_next      = work_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        // Drop the held beat once the far side takes it.
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        inv_next       = inv_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && radix_ok)
                begin
                    work_next    = value_mag;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    cnt_next     = '0;
                    neg_next     = value_neg;
                end
            end
            ST_DIV:
            begin
                work_next = quot;
                if (digit_done)
                begin
                    // Start the next digit on the fresh quotient.
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    rem_next     = rem_sub[DIGIT_W-1:0];
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            ST_SIGN:
            begin
                // At least one digit always follows, so the sign is never last.
                if (neg_reg && out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    inv_next       = 1'b0;
                end
            end
            ST_READ:
            begin
                cnt_next = cnt_minus;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(ram_rdata);
                    last_next      = (cnt_reg == '0);
                    inv_next       = 1'b0;
                end
            end
            ST_BAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_NUL;
                    last_next      = 1'b1;
                    inv_next       = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
            if (cfg_we)
                radix_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
        inv_reg  <= inv_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign invalid   = inv_reg;

endmodule

>>> rtl/core/itoa_checker.sv
// Port-level checker for the integer-to-ASCII converter, bound to its top level.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_port_checks (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [itoa_pkg::CHAR_W-1:0]   character,
    input logic                          last,
    input logic                          invalid
);

    import itoa_pkg::*;

    // A held beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(character) && $stable(last)
            && $stable(invalid))
    else $error("output beat changed while stalled");

    // One item at a time: the input closes right after a beat is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken while a conversion is in flight");

    // An invalid-radix beat is empty and ends its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> last && (character == CHAR_NUL))
    else $error("invalid beat is not a lone NUL");

    // Valid beats carry a sign or a digit only, and the sign never ends a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !invalid |->
            ((character == CHAR_MINUS) && !last)
            || ((character >= CHAR_ZERO) && (character <= CHAR_NINE))
            || ((character >= CHAR_UPA) && (character <= CHAR_UPF)))
    else $error("unexpected character on output");

endmodule

bind integer_to_ascii_radix itoa_port_checks u_itoa_port_checks (.*);
